// ----- design/rpp_pkg.sv -----
// Shared widths, register codes and item types for the radar point projector.
package rpp_pkg;

   // World coordinate and heading formats
   localparam int COORD_BITS  = 24;
   localparam int ANGLE_BITS  = 16;

   // Fixed register widths
   localparam int SCALE_BITS  = 16;
   localparam int CENTER_BITS = 12;
   localparam int RADIUS_BITS = 11;
   localparam int SCREEN_BITS = 14;

   // Datapath widths
   localparam int DELTA_BITS  = COORD_BITS + 1;           // point minus viewer
   localparam int TRIG_BITS   = 18;                       // signed Q15 sine/cosine
   localparam int PROD_BITS   = DELTA_BITS + TRIG_BITS;   // offset times trig
   localparam int POS_BITS    = COORD_BITS + 3;           // forward/right, pixel Q.8
   localparam int SUMSQ_BITS  = 2 * POS_BITS;             // squared length
   localparam int ROOT_BITS   = POS_BITS;                 // integer root of length
   localparam int R8_BITS     = RADIUS_BITS + 8;          // radius in Q.8 pixels
   localparam int QUOT_BITS   = R8_BITS;                  // clamped offset magnitude
   localparam int NUM_BITS    = POS_BITS + R8_BITS;       // |offset| * radius
   localparam int RR_BITS     = 2 * RADIUS_BITS;          // radius squared

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Register file
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VIEWER_X        = 3'd0,
      CSR_VIEWER_Y        = 3'd1,
      CSR_HEADING         = 3'd2,
      CSR_PIXELS_PER_UNIT = 3'd3,
      CSR_CENTER_X        = 3'd4,
      CSR_CENTER_Y        = 3'd5,
      CSR_RADIUS          = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] viewer_x;
      logic signed [COORD_BITS-1:0] viewer_y;
      logic        [ANGLE_BITS-1:0] heading;
      logic        [SCALE_BITS-1:0] pixels_per_unit;
      logic       [CENTER_BITS-1:0] center_x;
      logic       [CENTER_BITS-1:0] center_y;
      logic       [RADIUS_BITS-1:0] radius;
   } config_type;

   // Item handed from the front part to the back part
   typedef struct packed {
      logic signed [POS_BITS-1:0] px;
      logic signed [POS_BITS-1:0] py;
      logic      [SUMSQ_BITS-1:0] sumsq;
      logic                       clamp;
      logic                       coincident;
   } entry_type;

endpackage

// ----- design/rpp_front.sv -----
// Front part: offset, heading rotation, scaling and clamp decision, one item per cycle while the queue takes items.
module rpp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  rpp_pkg::config_type                 cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rpp_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [rpp_pkg::COORD_BITS-1:0] req_point_y,
   input  logic                                queue_full,
   output logic                                push,
   output rpp_pkg::entry_type                  push_entry
);

   localparam int NSTAGE = 11;

   logic              [NSTAGE-1:0] valid_ff, valid_in;
   logic                           en;

   // carried fields
   logic signed [rpp_pkg::DELTA_BITS-1:0] dx_ff [0:4];
   logic signed [rpp_pkg::DELTA_BITS-1:0] dy_ff [0:4];
   logic                                  coinc_ff [0:9];
   logic [14:0]                           arg_ff [0:3][2];
   logic                                  neg_ff [0:3][2];
   logic [14:0]                           z2_ff [1:2][2];
   logic [16:0]                           t1_ff [2];
   logic [16:0]                           t3_ff [2];
   logic signed [rpp_pkg::TRIG_BITS-1:0]  trig_ff [2];
   logic signed [rpp_pkg::PROD_BITS-1:0]  prod_ff [4];
   logic signed [rpp_pkg::POS_BITS-1:0]   fwd_ff, rgt_ff;
   logic signed [rpp_pkg::POS_BITS+16:0]  fwd_sc_ff, rgt_sc_ff;
   logic signed [rpp_pkg::POS_BITS-1:0]   px_ff [8:9];
   logic signed [rpp_pkg::POS_BITS-1:0]   py_ff [8:9];
   logic [rpp_pkg::SUMSQ_BITS-1:0]        pxx_ff, pyy_ff;
   logic [rpp_pkg::RR_BITS-1:0]           rr_ff;
   rpp_pkg::entry_type                    entry_ff;

   logic [31:0] phase_s, phase_c;

   function automatic logic [14:0] quarter_arg(input logic [31:0] phase);
      logic [14:0] z;
      z = {1'b0, phase[29:16]};
      return phase[30] ? (15'd16384 - z) : z;
   endfunction

   // Stall the whole front only when its last item cannot enter the queue
   assign en        = !(valid_ff[NSTAGE-1] && queue_full);
   assign req_ready = en;
   assign push      = valid_ff[NSTAGE-1] && !queue_full;
   assign push_entry = entry_ff;

   assign valid_in = {valid_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Sine phase and cosine phase (a quarter turn ahead)
   always_comb begin
      phase_s = {cfg.heading, {(32-rpp_pkg::ANGLE_BITS){1'b0}}};
      phase_c = phase_s + 32'h4000_0000;
   end

   // Stage 1: offset from the viewer, quarter-wave arguments; advance carried fields
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff[0]     <= rpp_pkg::DELTA_BITS'(req_point_x) - rpp_pkg::DELTA_BITS'(cfg.viewer_x);
         dy_ff[0]     <= rpp_pkg::DELTA_BITS'(req_point_y) - rpp_pkg::DELTA_BITS'(cfg.viewer_y);
         coinc_ff[0]  <= (req_point_x == cfg.viewer_x) && (req_point_y == cfg.viewer_y);
         arg_ff[0][0] <= quarter_arg(phase_s);
         arg_ff[0][1] <= quarter_arg(phase_c);
         neg_ff[0][0] <= phase_s[31];
         neg_ff[0][1] <= phase_c[31];
         for (int k = 1; k < 5; k++) begin
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
         end
         for (int k = 1; k < 10; k++) begin
            coinc_ff[k] <= coinc_ff[k-1];
         end
         for (int k = 1; k < 4; k++) begin
            arg_ff[k] <= arg_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   // Advance the square and the pixel offsets
   always_ff @(posedge clock) begin
      if (en) begin
         z2_ff[2] <= z2_ff[1];
         px_ff[9] <= px_ff[8];
         py_ff[9] <= py_ff[8];
      end
   end

   // Stages 2 to 5: quarter-wave sine polynomial, one multiply per stage
   for (genvar l = 0; l < 2; l++) begin : g_trig
      logic [29:0] sq_m;
      logic [27:0] c_m;
      logic [31:0] t_m;
      logic [31:0] s_m;
      logic [16:0] mag;

      always_comb begin
         sq_m = 30'(arg_ff[0][l]) * 30'(arg_ff[0][l]);
         c_m  = 28'(13'd4640) * 28'(z2_ff[1][l]);
         t_m  = 32'(t1_ff[l]) * 32'(z2_ff[2][l]);
         s_m  = 32'(t3_ff[l]) * 32'(arg_ff[3][l]);
         mag  = s_m[31:15];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            z2_ff[1][l] <= sq_m[28:14];
            t1_ff[l]    <= 17'd42048 - 17'(c_m[27:14]);
            t3_ff[l]    <= 17'd102944 - 17'(t_m[31:14]);
            trig_ff[l]  <= neg_ff[3][l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
         end
      end
   end

   // Stage 6: rotation products (lane 0 sine, lane 1 cosine)
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= rpp_pkg::PROD_BITS'(dx_ff[4]) * rpp_pkg::PROD_BITS'(trig_ff[1]);
         prod_ff[1] <= rpp_pkg::PROD_BITS'(dy_ff[4]) * rpp_pkg::PROD_BITS'(trig_ff[0]);
         prod_ff[2] <= rpp_pkg::PROD_BITS'(dx_ff[4]) * rpp_pkg::PROD_BITS'(trig_ff[0]);
         prod_ff[3] <= rpp_pkg::PROD_BITS'(dy_ff[4]) * rpp_pkg::PROD_BITS'(trig_ff[1]);
      end
   end

   // Stage 7: forward and right, truncated toward zero
   logic signed [rpp_pkg::PROD_BITS:0] fsum, rsum, fadj, radj;
   always_comb begin
      fsum = (rpp_pkg::PROD_BITS+1)'(prod_ff[0]) + (rpp_pkg::PROD_BITS+1)'(prod_ff[1]);
      rsum = (rpp_pkg::PROD_BITS+1)'(prod_ff[2]) - (rpp_pkg::PROD_BITS+1)'(prod_ff[3]);
      fadj = fsum + $signed({{(rpp_pkg::PROD_BITS-14){1'b0}}, {15{fsum[rpp_pkg::PROD_BITS]}}});
      radj = rsum + $signed({{(rpp_pkg::PROD_BITS-14){1'b0}}, {15{rsum[rpp_pkg::PROD_BITS]}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_ff <= rpp_pkg::POS_BITS'(fadj >>> 15);
         rgt_ff <= rpp_pkg::POS_BITS'(radj >>> 15);
      end
   end

   // Stage 8: scale to pixels
   logic signed [rpp_pkg::POS_BITS+16:0] ppu_s;
   assign ppu_s = (rpp_pkg::POS_BITS+17)'($signed({1'b0, cfg.pixels_per_unit}));

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_sc_ff <= (rpp_pkg::POS_BITS+17)'(fwd_ff) * ppu_s;
         rgt_sc_ff <= (rpp_pkg::POS_BITS+17)'(rgt_ff) * ppu_s;
      end
   end

   // Stage 9: drop the scale fraction, forward points up the screen
   logic signed [rpp_pkg::POS_BITS+16:0] fsc_adj, rsc_adj;
   always_comb begin
      fsc_adj = fwd_sc_ff + $signed({{(rpp_pkg::POS_BITS+1){1'b0}},
                                     {16{fwd_sc_ff[rpp_pkg::POS_BITS+16]}}});
      rsc_adj = rgt_sc_ff + $signed({{(rpp_pkg::POS_BITS+1){1'b0}},
                                     {16{rgt_sc_ff[rpp_pkg::POS_BITS+16]}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[8] <= rpp_pkg::POS_BITS'(rsc_adj >>> 16);
         py_ff[8] <= -rpp_pkg::POS_BITS'(fsc_adj >>> 16);
      end
   end

   // Stage 10: squares of the offset and of the radius
   always_ff @(posedge clock) begin
      if (en) begin
         pxx_ff <= rpp_pkg::SUMSQ_BITS'(rpp_pkg::SUMSQ_BITS'(px_ff[8]) *
                                        rpp_pkg::SUMSQ_BITS'(px_ff[8]));
         pyy_ff <= rpp_pkg::SUMSQ_BITS'(rpp_pkg::SUMSQ_BITS'(py_ff[8]) *
                                        rpp_pkg::SUMSQ_BITS'(py_ff[8]));
         rr_ff  <= rpp_pkg::RR_BITS'(cfg.radius) * rpp_pkg::RR_BITS'(cfg.radius);
      end
   end

   // Stage 11: length squared against radius squared
   logic [rpp_pkg::SUMSQ_BITS-1:0] sumsq, lim;
   always_comb begin
      sumsq = pxx_ff + pyy_ff;
      lim   = rpp_pkg::SUMSQ_BITS'({rr_ff, 16'h0000});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_ff.px         <= px_ff[9];
         entry_ff.py         <= py_ff[9];
         entry_ff.sumsq      <= sumsq;
         entry_ff.clamp      <= sumsq > lim;
         entry_ff.coincident <= coinc_ff[9];
      end
   end

endmodule

// ----- design/rpp_queue.sv -----
// Short item queue between the front and back parts.
module rpp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rpp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               nonempty,
   output rpp_pkg::entry_type pop_entry
);

   rpp_pkg::entry_type              slot_ff [rpp_pkg::QUEUE_DEPTH];
   logic [rpp_pkg::QPTR_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [rpp_pkg::QPTR_BITS:0]     count_ff, count_in;

   assign full      = count_ff == (rpp_pkg::QPTR_BITS+1)'(rpp_pkg::QUEUE_DEPTH);
   assign nonempty  = count_ff != '0;
   assign pop_entry = slot_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (rpp_pkg::QPTR_BITS+1)'(push) - (rpp_pkg::QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Hold items
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rpp_pkg::QPTR_BITS+1)'(rpp_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push lost");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      rpp_pkg::QPTR_BITS'(wr_ff - rd_ff) == rpp_pkg::QPTR_BITS'(count_ff))
      else $error("queue pointers and count disagree");

endmodule

// ----- design/rpp_back.sv -----
// Back part: pipelined square root, clamp division and centre offset.
module rpp_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rpp_pkg::config_type                    cfg,
   input  logic                                   in_valid,
   input  rpp_pkg::entry_type                     in_entry,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rpp_pkg::SCREEN_BITS-1:0] rsp_screen_x,
   output logic signed [rpp_pkg::SCREEN_BITS-1:0] rsp_screen_y,
   output logic                                   rsp_visible
);

   localparam int R = rpp_pkg::ROOT_BITS;
   localparam int Q = rpp_pkg::QUOT_BITS;
   localparam int SW = rpp_pkg::SUMSQ_BITS + 2;
   localparam int NW = rpp_pkg::NUM_BITS + 1;

   logic en;

   // Square root stages
   logic [R:0]                            sq_val_ff;
   logic [rpp_pkg::SUMSQ_BITS-1:0]        sq_rem_ff  [0:R];
   logic [R-1:0]                          sq_root_ff [0:R];
   logic signed [rpp_pkg::POS_BITS-1:0]   sq_px_ff   [0:R];
   logic signed [rpp_pkg::POS_BITS-1:0]   sq_py_ff   [0:R];
   logic                                  sq_clamp_ff[0:R];
   logic                                  sq_coinc_ff[0:R];

   // Division stages, index 0 holds the numerators
   logic [Q:0]                            dv_val_ff;
   logic [rpp_pkg::NUM_BITS-1:0]          dv_rem_ff  [0:Q][2];
   logic [Q-1:0]                          dv_q_ff    [0:Q][2];
   logic [R-1:0]                          dv_len_ff  [0:Q];
   logic signed [rpp_pkg::POS_BITS-1:0]   dv_pos_ff  [0:Q][2];
   logic                                  dv_clamp_ff[0:Q];
   logic                                  dv_coinc_ff[0:Q];

   // Result register
   logic                                   out_val_ff;
   logic signed [rpp_pkg::SCREEN_BITS-1:0] sx_ff, sy_ff;
   logic                                   vis_ff;

   assign en           = rsp_ready || !out_val_ff;
   assign pop          = en && in_valid;
   assign rsp_valid    = out_val_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;
   assign rsp_visible  = vis_ff;

   // Advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_val_ff  <= '0;
         dv_val_ff  <= '0;
         out_val_ff <= 1'b0;
      end else if (en) begin
         sq_val_ff  <= {sq_val_ff[R-1:0], in_valid};
         dv_val_ff  <= {dv_val_ff[Q-1:0], sq_val_ff[R]};
         out_val_ff <= dv_val_ff[Q];
      end
   end

   // Load an item from the queue
   always_ff @(posedge clock) begin
      if (en) begin
         sq_rem_ff[0]   <= in_entry.sumsq;
         sq_root_ff[0]  <= '0;
         sq_px_ff[0]    <= in_entry.px;
         sq_py_ff[0]    <= in_entry.py;
         sq_clamp_ff[0] <= in_entry.clamp;
         sq_coinc_ff[0] <= in_entry.coincident;
      end
   end

   // One root bit per stage
   for (genvar k = 0; k < R; k++) begin : g_sqrt
      localparam int B = R - 1 - k;
      logic [SW-1:0] trial, rem_x;

      always_comb begin
         trial = (SW'(sq_root_ff[k]) << (B + 1)) + (SW'(1) << (2 * B));
         rem_x = SW'(sq_rem_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_x >= trial) begin
               sq_rem_ff[k+1]  <= rpp_pkg::SUMSQ_BITS'(rem_x - trial);
               sq_root_ff[k+1] <= sq_root_ff[k] | (R'(1) << B);
            end else begin
               sq_rem_ff[k+1]  <= sq_rem_ff[k];
               sq_root_ff[k+1] <= sq_root_ff[k];
            end
            sq_px_ff[k+1]    <= sq_px_ff[k];
            sq_py_ff[k+1]    <= sq_py_ff[k];
            sq_clamp_ff[k+1] <= sq_clamp_ff[k];
            sq_coinc_ff[k+1] <= sq_coinc_ff[k];
         end
      end
   end

   // Numerators: offset magnitude times radius in Q.8
   logic [rpp_pkg::POS_BITS-1:0] mag_x, mag_y;
   logic [rpp_pkg::R8_BITS-1:0]  r8;
   always_comb begin
      mag_x = sq_px_ff[R][rpp_pkg::POS_BITS-1] ? rpp_pkg::POS_BITS'(-sq_px_ff[R])
                                                : rpp_pkg::POS_BITS'(sq_px_ff[R]);
      mag_y = sq_py_ff[R][rpp_pkg::POS_BITS-1] ? rpp_pkg::POS_BITS'(-sq_py_ff[R])
                                                : rpp_pkg::POS_BITS'(sq_py_ff[R]);
      r8    = {cfg.radius, 8'h00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0][0] <= rpp_pkg::NUM_BITS'(mag_x) * rpp_pkg::NUM_BITS'(r8);
         dv_rem_ff[0][1] <= rpp_pkg::NUM_BITS'(mag_y) * rpp_pkg::NUM_BITS'(r8);
         dv_q_ff[0][0]   <= '0;
         dv_q_ff[0][1]   <= '0;
         dv_len_ff[0]    <= sq_root_ff[R];
         dv_pos_ff[0][0] <= sq_px_ff[R];
         dv_pos_ff[0][1] <= sq_py_ff[R];
         dv_clamp_ff[0]  <= sq_clamp_ff[R];
         dv_coinc_ff[0]  <= sq_coinc_ff[R];
      end
   end

   // One quotient bit per stage for both lanes
   for (genvar k = 0; k < Q; k++) begin : g_div
      localparam int B = Q - 1 - k;
      logic [NW-1:0] dsh;

      assign dsh = NW'(dv_len_ff[k]) << B;

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [NW-1:0] rem_x;
         assign rem_x = NW'(dv_rem_ff[k][l]);

         always_ff @(posedge clock) begin
            if (en) begin
               if (rem_x >= dsh) begin
                  dv_rem_ff[k+1][l] <= rpp_pkg::NUM_BITS'(rem_x - dsh);
                  dv_q_ff[k+1][l]   <= dv_q_ff[k][l] | (Q'(1) << B);
               end else begin
                  dv_rem_ff[k+1][l] <= dv_rem_ff[k][l];
                  dv_q_ff[k+1][l]   <= dv_q_ff[k][l];
               end
               dv_pos_ff[k+1][l] <= dv_pos_ff[k][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_len_ff[k+1]   <= dv_len_ff[k];
            dv_clamp_ff[k+1] <= dv_clamp_ff[k];
            dv_coinc_ff[k+1] <= dv_coinc_ff[k];
         end
      end
   end

   // Pick clamped or raw offset, truncate to whole pixels, add the centre
   logic signed [rpp_pkg::POS_BITS-1:0] fin [2];
   logic signed [rpp_pkg::POS_BITS-1:0] adj [2];
   logic signed [rpp_pkg::POS_BITS-1:0] scr [2];
   logic [rpp_pkg::CENTER_BITS-1:0]     ctr [2];

   assign ctr[0] = cfg.center_x;
   assign ctr[1] = cfg.center_y;

   for (genvar l = 0; l < 2; l++) begin : g_fin
      logic signed [rpp_pkg::POS_BITS-1:0] qs;
      always_comb begin
         qs = rpp_pkg::POS_BITS'($signed({1'b0, dv_q_ff[Q][l]}));
         if (dv_clamp_ff[Q]) begin
            fin[l] = dv_pos_ff[Q][l][rpp_pkg::POS_BITS-1] ? -qs : qs;
         end else begin
            fin[l] = dv_pos_ff[Q][l];
         end
         adj[l] = fin[l] + $signed({{(rpp_pkg::POS_BITS-8){1'b0}},
                                    {8{fin[l][rpp_pkg::POS_BITS-1]}}});
         scr[l] = rpp_pkg::POS_BITS'($signed({1'b0, ctr[l]})) + (adj[l] >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (dv_coinc_ff[Q]) begin
            sx_ff  <= '0;
            sy_ff  <= '0;
            vis_ff <= 1'b0;
         end else begin
            sx_ff  <= scr[0][rpp_pkg::SCREEN_BITS-1:0];
            sy_ff  <= scr[1][rpp_pkg::SCREEN_BITS-1:0];
            vis_ff <= 1'b1;
         end
      end
   end

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> en)
      else $error("pop while back part stalled");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_val_ff && !rsp_ready) |=> out_val_ff && $stable(sx_ff) && $stable(vis_ff))
      else $error("result changed while stalled");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (out_val_ff && !vis_ff) |-> (sx_ff == '0 && sy_ff == '0))
      else $error("coincident point gives nonzero screen position");

endmodule

// ----- design/radar_point_projection.sv -----
// Top level of the radar point projector: registers, front part, queue and back part.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | req_point_x, req_point_y
//   rsp_    | out       | rsp_valid / rsp_ready | rsp_screen_x, rsp_screen_y, rsp_visible
//   csr_    | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One point is accepted per cycle while req_ready is high. A point passes the front
// (sine polynomial, rotation, scaling, squares), a queue slot, and the back (one
// load stage, 27 root stages, one numerator stage, 19 division stages, the result).
// Reset clears the valid flags and loads the register defaults; nothing is swept.
// A stalled result stalls the back part only; the front keeps filling the
// four-entry queue and lowers req_ready once its last stage cannot push.
module radar_point_projection (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [rpp_pkg::COORD_BITS-1:0]   req_point_x,
   input  logic signed [rpp_pkg::COORD_BITS-1:0]   req_point_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [rpp_pkg::SCREEN_BITS-1:0]  rsp_screen_x,
   output logic signed [rpp_pkg::SCREEN_BITS-1:0]  rsp_screen_y,
   output logic                                    rsp_visible,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rpp_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [rpp_pkg::COORD_BITS-1:0]          csr_data
);

   rpp_pkg::config_type cfg_ff, cfg_in;
   rpp_pkg::entry_type  push_entry, pop_entry;
   logic                push, pop, queue_full, queue_nonempty;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rpp_pkg::csr_index_type'(csr_index))
            rpp_pkg::CSR_VIEWER_X:        cfg_in.viewer_x = $signed(csr_data);
            rpp_pkg::CSR_VIEWER_Y:        cfg_in.viewer_y = $signed(csr_data);
            rpp_pkg::CSR_HEADING:
               cfg_in.heading = csr_data[rpp_pkg::ANGLE_BITS-1:0];
            rpp_pkg::CSR_PIXELS_PER_UNIT:
               cfg_in.pixels_per_unit = csr_data[rpp_pkg::SCALE_BITS-1:0];
            rpp_pkg::CSR_CENTER_X:
               cfg_in.center_x = csr_data[rpp_pkg::CENTER_BITS-1:0];
            rpp_pkg::CSR_CENTER_Y:
               cfg_in.center_y = csr_data[rpp_pkg::CENTER_BITS-1:0];
            rpp_pkg::CSR_RADIUS:
               cfg_in.radius = csr_data[rpp_pkg::RADIUS_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.viewer_x        <= '0;
         cfg_ff.viewer_y        <= '0;
         cfg_ff.heading         <= '0;
         cfg_ff.pixels_per_unit <= rpp_pkg::SCALE_BITS'(4096);
         cfg_ff.center_x        <= rpp_pkg::CENTER_BITS'(128);
         cfg_ff.center_y        <= rpp_pkg::CENTER_BITS'(128);
         cfg_ff.radius          <= rpp_pkg::RADIUS_BITS'(96);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   rpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .nonempty   (queue_nonempty),
      .pop_entry  (pop_entry)
   );

   rpp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (queue_nonempty),
      .in_entry     (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_screen_x (rsp_screen_x),
      .rsp_screen_y (rsp_screen_y),
      .rsp_visible  (rsp_visible)
   );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the radar point projector.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   // Index past the end of the register file; writes to it are dropped
   localparam logic [rpp_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct {
      logic signed [rpp_pkg::SCREEN_BITS-1:0] screen_x;
      logic signed [rpp_pkg::SCREEN_BITS-1:0] screen_y;
      logic                                   visible;
   } blip_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic signed [rpp_pkg::COORD_BITS-1:0]  req_point_x;
   logic signed [rpp_pkg::COORD_BITS-1:0]  req_point_y;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic signed [rpp_pkg::SCREEN_BITS-1:0] rsp_screen_x;
   logic signed [rpp_pkg::SCREEN_BITS-1:0] rsp_screen_y;
   logic                                   rsp_visible;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [rpp_pkg::CSR_INDEX_BITS-1:0]     csr_index;
   logic [rpp_pkg::COORD_BITS-1:0]         csr_data;

   blip_type pending_blips[$];
   int       error_count;
   int       quiet_cycles;
   int       stall_left;

   // Shadow copy of the display registers
   longint shadow_vx, shadow_vy, shadow_heading, shadow_ppu;
   longint shadow_cx, shadow_cy, shadow_radius;

   radar_point_projection uut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Polynomial quarter sine, Q14 in and Q15 out
   function automatic longint quarter_sine(input longint z);
      longint z2, t;
      z2 = (z * z) / 16384;
      t  = (4640 * z2) / 16384;
      t  = 42048 - t;
      t  = (t * z2) / 16384;
      t  = 102944 - t;
      return (t * z) / 32768;
   endfunction

   function automatic longint sine_of_phase(input logic [31:0] phase);
      longint v;
      v = phase[30] ? quarter_sine(16384 - longint'(phase[29:16]))
                    : quarter_sine(longint'(phase[29:16]));
      return phase[31] ? -v : v;
   endfunction

   function automatic longint floor_root(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // Project one world point onto the radar display
   function automatic blip_type project_point(
         input logic signed [rpp_pkg::COORD_BITS-1:0] x,
         input logic signed [rpp_pkg::COORD_BITS-1:0] y);
      blip_type    blip;
      longint      dx, dy, s, c, fwd, rgt, px, py, r8, len;
      logic [31:0] phase;
      dx = longint'(x) - shadow_vx;
      dy = longint'(y) - shadow_vy;
      if (dx == 0 && dy == 0) begin
         blip.screen_x = '0;
         blip.screen_y = '0;
         blip.visible  = 1'b0;
         return blip;
      end
      phase = 32'(shadow_heading) << (32 - rpp_pkg::ANGLE_BITS);
      s   = sine_of_phase(phase);
      c   = sine_of_phase(phase + 32'h4000_0000);
      fwd = (dx * c + dy * s) / 32768;
      rgt = (dx * s - dy * c) / 32768;
      px  = (rgt * shadow_ppu) / 65536;
      py  = -((fwd * shadow_ppu) / 65536);
      while (magnitude(px) >= (64'sd1 << 30) || magnitude(py) >= (64'sd1 << 30)) begin
         px /= 2;
         py /= 2;
      end
      // Pull far points back onto the circle
      r8 = shadow_radius * 256;
      if (px * px + py * py > r8 * r8) begin
         len = floor_root(longint'(px * px + py * py));
         if (len > 0) begin
            px = (px * r8) / len;
            py = (py * r8) / len;
         end
      end
      blip.screen_x = rpp_pkg::SCREEN_BITS'(shadow_cx + px / 256);
      blip.screen_y = rpp_pkg::SCREEN_BITS'(shadow_cy + py / 256);
      blip.visible  = 1'b1;
      return blip;
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one point; valid stays high when the next point follows at once
   task automatic send_point(input logic signed [rpp_pkg::COORD_BITS-1:0] x,
                             input logic signed [rpp_pkg::COORD_BITS-1:0] y);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (!req_ready);
      pending_blips.push_back(project_point(x, y));
   endtask

   task automatic release_points();
      req_valid <= 1'b0;
   endtask

   task automatic write_register(input logic [rpp_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [rpp_pkg::COORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         rpp_pkg::CSR_VIEWER_X:
            shadow_vx      = longint'($signed(data));
         rpp_pkg::CSR_VIEWER_Y:
            shadow_vy      = longint'($signed(data));
         rpp_pkg::CSR_HEADING:
            shadow_heading = longint'(data[rpp_pkg::ANGLE_BITS-1:0]);
         rpp_pkg::CSR_PIXELS_PER_UNIT:
            shadow_ppu     = longint'(data[rpp_pkg::SCALE_BITS-1:0]);
         rpp_pkg::CSR_CENTER_X:
            shadow_cx      = longint'(data[rpp_pkg::CENTER_BITS-1:0]);
         rpp_pkg::CSR_CENTER_Y:
            shadow_cy      = longint'(data[rpp_pkg::CENTER_BITS-1:0]);
         rpp_pkg::CSR_RADIUS:
            shadow_radius  = longint'(data[rpp_pkg::RADIUS_BITS-1:0]);
         default: ;
      endcase
   endtask

   // Load the whole register set once the pipeline has drained
   task automatic load_display(input logic [rpp_pkg::COORD_BITS-1:0] vx,
                               input logic [rpp_pkg::COORD_BITS-1:0] vy,
                               input logic [rpp_pkg::COORD_BITS-1:0] heading,
                               input logic [rpp_pkg::COORD_BITS-1:0] ppu,
                               input logic [rpp_pkg::COORD_BITS-1:0] cx,
                               input logic [rpp_pkg::COORD_BITS-1:0] cy,
                               input logic [rpp_pkg::COORD_BITS-1:0] radius);
      release_points();
      wait (pending_blips.size() == 0);
      @(posedge clock);
      write_register(rpp_pkg::CSR_VIEWER_X, vx);
      write_register(rpp_pkg::CSR_VIEWER_Y, vy);
      write_register(rpp_pkg::CSR_HEADING, heading);
      write_register(rpp_pkg::CSR_PIXELS_PER_UNIT, ppu);
      write_register(rpp_pkg::CSR_CENTER_X, cx);
      write_register(rpp_pkg::CSR_CENTER_Y, cy);
      write_register(rpp_pkg::CSR_RADIUS, radius);
      if ($urandom_range(0, 3) == 0)
         write_register(CSR_UNMAPPED, rpp_pkg::COORD_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Points near the viewer at a random distance scale
   task automatic send_offset_point();
      int     reach;
      longint ox, oy;
      reach = $urandom_range(0, 24);
      ox = longint'($signed($urandom)) % (64'sd1 << reach);
      oy = longint'($signed($urandom)) % (64'sd1 << reach);
      send_point(rpp_pkg::COORD_BITS'(shadow_vx + ox), rpp_pkg::COORD_BITS'(shadow_vy + oy));
   endtask

   // Reset values: coincident point, axes, two corners of the coordinate range and an off-axis point
   task automatic test_reset_defaults();
      send_point(0, 0);
      send_point(24'sh7FFFFF, 24'sh7FFFFF);
      send_point(-24'sh800000, -24'sh800000);
      send_point(24'sh000100, 0);
      send_point(0, 24'sh000100);
      send_point(24'sh000800, -24'sh000600);
   endtask

   // Register extremes, each quadrant, zero scale and zero radius
   task automatic test_directed_extremes();
      load_display(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h00FFFF, 24'h000FFF, 24'h000000,
                   24'h0007FF);
      send_point(24'sh7FFFFF, -24'sh800000);
      send_point(-24'sh800000, 24'sh7FFFFF);
      send_point(-24'sh800000, 24'sh7FFFFF - 24'sh000100);
      load_display(24'h000000, 24'h000000, 24'h004000, 24'h000000, 24'h000800, 24'h000800,
                   24'h000100);
      send_point(24'sh001000, 24'sh002000);
      send_point(0, 0);
      load_display(24'h000000, 24'h000000, 24'h008000, 24'h00FFFF, 24'h000080, 24'h000080,
                   24'h000000);
      send_point(24'sh001000, -24'sh002000);
      send_point(24'sh7FFFFF, 24'sh7FFFFF);
      load_display(24'h001234, 24'hFFEDCC, 24'h00C000, 24'h010000 | 24'h000400,
                   24'hFFF040, 24'h000040, 24'hFFF860);
      send_point(24'sh001234 + 24'sh000300, -24'sh001234);
      send_point(24'sh001234, -24'sh001234);
      send_point(24'sh001234, 24'sh004000);
   endtask

   function automatic logic [rpp_pkg::COORD_BITS-1:0] pick_field(input int bits,
                                                                 input longint top);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return rpp_pkg::COORD_BITS'(top);
         default: return rpp_pkg::COORD_BITS'($urandom) & ((24'd1 << bits) - 24'd1);
      endcase
   endfunction

   // Random phases under varied display settings
   task automatic test_random_phases();
      for (int phase_no = 0; phase_no < 8; phase_no++) begin
         load_display(rpp_pkg::COORD_BITS'($urandom), rpp_pkg::COORD_BITS'($urandom),
                      pick_field(rpp_pkg::ANGLE_BITS, 65535),
                      pick_field(rpp_pkg::SCALE_BITS, 65535),
                      pick_field(rpp_pkg::CENTER_BITS, 4095),
                      pick_field(rpp_pkg::CENTER_BITS, 4095),
                      pick_field(rpp_pkg::RADIUS_BITS, 2047));
         for (int n = 0; n < 210; n++) begin
            case ($urandom_range(0, 9))
               0:       send_point(rpp_pkg::COORD_BITS'(shadow_vx),
                                   rpp_pkg::COORD_BITS'(shadow_vy));
               1, 2:    send_point(rpp_pkg::COORD_BITS'($urandom),
                                   rpp_pkg::COORD_BITS'($urandom));
               default: send_offset_point();
            endcase
         end
      end
      release_points();
   endtask

   // Result side back-pressure: mostly ready, short and occasional long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= random_gap();
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      blip_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_blips.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_blips.pop_front();
            if (rsp_visible !== want.visible)
               report_mismatch($sformatf("visible %0b want %0b", rsp_visible, want.visible));
            if (rsp_screen_x !== want.screen_x)
               report_mismatch($sformatf("screen_x %0d want %0d", rsp_screen_x, want.screen_x));
            if (rsp_screen_y !== want.screen_y)
               report_mismatch($sformatf("screen_y %0d want %0d", rsp_screen_y, want.screen_y));
         end
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count    = 0;
      shadow_vx      = 0;
      shadow_vy      = 0;
      shadow_heading = 0;
      shadow_ppu     = 4096;
      shadow_cx      = 128;
      shadow_cy      = 128;
      shadow_radius  = 96;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_extremes();
      test_random_phases();
      wait (pending_blips.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_blips.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
